/* rtl/core/bfd_pkg.sv */
// Package with the parser phase type and the frame sync constants.
package bfd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    typedef enum logic [9:0] {
        PH_SYNC1     = 10'b00_0000_0001,
        PH_SYNC2     = 10'b00_0000_0010,
        PH_CLASS     = 10'b00_0000_0100,
        PH_ID        = 10'b00_0000_1000,
        PH_LEN_LO    = 10'b00_0001_0000,
        PH_LEN_HI    = 10'b00_0010_0000,
        PH_PAYLOAD   = 10'b00_0100_0000,
        PH_CK_A      = 10'b00_1000_0000,
        PH_CK_B_GOOD = 10'b01_0000_0000,
        PH_CK_B_BAD  = 10'b10_0000_0000
    } phase_t;

endpackage

/* rtl/core/bfd_rx_if.sv */
// Channel interface that carries one received byte per item.
interface bfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/bfd_res_if.sv */
// Channel interface that carries one parser result per item.
interface bfd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic        checksum_ok;
    logic        frame_end;

    modport source (output valid, output payload_byte, output byte_index,
                    output frame_class, output frame_id, output frame_length,
                    output checksum_ok, output frame_end, input ready);
    modport sink (input valid, input payload_byte, input byte_index,
                  input frame_class, input frame_id, input frame_length,
                  input checksum_ok, input frame_end, output ready);
endinterface

/* rtl/core/binary_frame_deframer_fletcher8_top.sv */
// Frame parser top level: sync hunt, header capture, payload output and Fletcher check.
//
//   Channel | Direction | Payload                                   | Handshake
//   rx      | in        | rx_byte                                   | valid/ready
//   res     | out       | payload_byte, byte_index, frame_class,    | valid/ready
//           |           | frame_id, frame_length, checksum_ok,      |
//           |           | frame_end                                 |
//
// One byte is accepted per cycle unless the parser stalls; its result, if any, is registered
// in the result register when the byte leaves the input register.
// The input register and the result register each hold one item, so the
// parser keeps accepting while a result waits, and stalls only when both are full.
// Reset puts the parser in the sync hunt with all sums and held fields at zero.
module binary_frame_deframer_fletcher8_top (
    input  logic       clk,
    input  logic       rst_n,
    bfd_rx_if.sink     rx,
    bfd_res_if.source  res
);
    import bfd_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        advance;

    phase_t      phase_reg, phase_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] count_inc;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  add_a, add_b, add_base_a, add_base_b;

    logic        emit;
    logic        emit_ok;
    logic        emit_end;
    logic        res_valid_reg, res_valid_next;
    logic [7:0]  payload_reg;
    logic [15:0] index_reg;
    logic [7:0]  res_class_reg;
    logic [7:0]  res_id_reg;
    logic [15:0] res_length_reg;
    logic        ok_reg;
    logic        end_reg;

    assign advance  = in_valid_reg && (!res_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_comb
    begin
        if (rx.valid && rx.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    assign add_base_a = (phase_reg == PH_CLASS) ? 8'd0 : sum_a_reg;
    assign add_base_b = (phase_reg == PH_CLASS) ? 8'd0 : sum_b_reg;
    assign add_a      = add_base_a + in_byte_reg;
    assign add_b      = add_base_b + add_a;
    assign count_inc  = count_reg + 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        emit        = 1'b0;
        emit_ok     = 1'b0;
        emit_end    = 1'b0;
        case (phase_reg)
            PH_SYNC2:
            begin
                if (in_byte_reg == SYNC_SECOND)
                begin
                    phase_next = PH_CLASS;
                end
                else if (in_byte_reg != SYNC_FIRST)
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CLASS:
            begin
                class_next = in_byte_reg;
                sum_a_next = add_a;
                sum_b_next = add_b;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                id_next    = in_byte_reg;
                sum_a_next = add_a;
                sum_b_next = add_b;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = {8'd0, in_byte_reg};
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = {in_byte_reg, length_reg[7:0]};
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                count_next  = 16'd0;
                if ({in_byte_reg, length_reg[7:0]} == 16'd0)
                begin
                    phase_next = PH_CK_A;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                emit       = 1'b1;
                sum_a_next = add_a;
                sum_b_next = add_b;
                count_next = count_inc;
                if (count_inc >= length_reg)
                begin
                    phase_next = PH_CK_A;
                end
            end
            PH_CK_A:
            begin
                if (in_byte_reg == sum_a_reg)
                begin
                    phase_next = PH_CK_B_GOOD;
                end
                else
                begin
                    phase_next = PH_CK_B_BAD;
                end
            end
            PH_CK_B_GOOD:
            begin
                emit       = 1'b1;
                emit_end   = 1'b1;
                emit_ok    = (in_byte_reg == sum_b_reg);
                phase_next = PH_SYNC1;
            end
            PH_CK_B_BAD:
            begin
                emit       = 1'b1;
                emit_end   = 1'b1;
                phase_next = PH_SYNC1;
            end
            default:
            begin
                if (in_byte_reg == SYNC_FIRST)
                begin
                    phase_next = PH_SYNC2;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
        endcase
    end

    always_comb
    begin
        if (advance)
        begin
            res_valid_next = emit;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_SYNC1;
            class_reg     <= 8'd0;
            id_reg        <= 8'd0;
            length_reg    <= 16'd0;
            count_reg     <= 16'd0;
            sum_a_reg     <= 8'd0;
            sum_b_reg     <= 8'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                phase_reg  <= phase_next;
                class_reg  <= class_next;
                id_reg     <= id_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                sum_a_reg  <= sum_a_next;
                sum_b_reg  <= sum_b_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance && emit)
        begin
            payload_reg    <= emit_end ? 8'd0 : in_byte_reg;
            index_reg      <= emit_end ? 16'd0 : count_reg;
            res_class_reg  <= class_reg;
            res_id_reg     <= id_reg;
            res_length_reg <= length_reg;
            ok_reg         <= emit_ok;
            end_reg        <= emit_end;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.payload_byte = payload_reg;
    assign res.byte_index   = index_reg;
    assign res.frame_class  = res_class_reg;
    assign res.frame_id     = res_id_reg;
    assign res.frame_length = res_length_reg;
    assign res.checksum_ok  = ok_reg;
    assign res.frame_end    = end_reg;

endmodule
